// ----- hw/rtl/ppp_pkg.sv -----
// Shared types and fixed constants of the perspective point projection unit.
package ppp_pkg;

    localparam int PT_W       = 12;
    localparam int TRIG_W     = 16;
    localparam int CREG_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SCR_W      = 16;
    localparam int DEPTH_W    = 13;

    // Internal word widths that follow from the fixed field widths.
    localparam int Z0_W    = PT_W + 2;
    localparam int TPROD_W = PT_W + TRIG_W;
    localparam int ZPROD_W = Z0_W + TRIG_W;
    localparam int Y1_W    = 29;
    localparam int M_W     = Y1_W + TRIG_W;

    // Pipeline layout: eight front stages, one divider set-up stage, one stage
    // per quotient bit and one output stage.
    localparam int DIV_BITS   = SCR_W;
    localparam int DIV_BASE   = 8;
    localparam int NUM_STAGES = DIV_BASE + DIV_BITS + 2;

    localparam int NEAR_LIMIT = 10;

    localparam logic [DEPTH_W-1:0]       DEPTH_MAX     = 13'd8191;
    localparam logic signed [SCR_W-1:0]  SCR_MAX       = 16'sh7FFF;
    localparam logic signed [SCR_W-1:0]  SCR_MIN       = 16'sh8000;
    localparam logic [SCR_W-1:0]         MAG_POS_LIMIT = 16'd32767;
    localparam logic [SCR_W-1:0]         MAG_NEG_LIMIT = 16'd32768;

    localparam logic signed [TRIG_W-1:0] RST_COS_PITCH = 16'sd14378;
    localparam logic signed [TRIG_W-1:0] RST_SIN_PITCH = 16'sd7855;
    localparam logic signed [TRIG_W-1:0] RST_COS_YAW   = 16'sd12531;
    localparam logic signed [TRIG_W-1:0] RST_SIN_YAW   = 16'sd10555;
    localparam logic [CREG_W-1:0]        RST_CAM_DIST  = 12'd400;
    localparam logic [CREG_W-1:0]        RST_FOCAL     = 12'd500;
    localparam logic [CREG_W-1:0]        RST_SCR_CX    = 12'd512;
    localparam logic [CREG_W-1:0]        RST_SCR_CY    = 12'd384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_PITCH = 3'd0,
        REG_SIN_PITCH = 3'd1,
        REG_COS_YAW   = 3'd2,
        REG_SIN_YAW   = 3'd3,
        REG_CAM_DIST  = 3'd4,
        REG_FOCAL     = 3'd5,
        REG_SCR_CX    = 3'd6,
        REG_SCR_CY    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic signed [PT_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic                    visible;
        logic signed [SCR_W-1:0] screen_x;
        logic signed [SCR_W-1:0] screen_y;
        logic [DEPTH_W-1:0]      depth;
        logic                    saturated;
    } result_t;

    // Per-word control carried alongside the divider; lane 0 is x, lane 1 is y.
    typedef struct packed {
        logic               visible;
        logic [DEPTH_W-1:0] depth;
        logic [1:0]         neg;
        logic [1:0]         ovf;
    } div_ctl_t;

endpackage

// ----- hw/rtl/ppp_if.sv -----
// Handshake interfaces of the perspective point projection unit.
interface ppp_point_if
    import ppp_pkg::*;
();
    logic   valid;
    logic   ready;
    point_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppp_result_if
    import ppp_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppp_cfg_if
    import ppp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/perspective_point_projection_unit.sv -----
// Perspective point projection unit: fully pipelined rotate, project and divide datapath.

// Each word on the point channel is one integer 3D point. The camera distance is added to
// its z, the point is turned about the X axis and then the Y axis with the cosine and sine
// registers (signed fixed point with TRIG_FRAC_BITS fraction bits), and a point whose
// rotated depth is 10 or less comes out as invisible with all other fields zero. A visible
// point is projected to screen_x = centre x + x * focal / depth and
// screen_y = centre y - y * focal / depth, truncated toward zero and clamped to signed 16
// bits (saturated is set when either is clamped); depth carries the integer rotated depth,
// capped at 8191. The unit takes one point per clock while the result channel does not
// stall and returns one result word per point, in order. Each point passes through eight
// stages of multiply and add, one divider set-up stage, sixteen stages of restoring
// division that settle one quotient bit each for both coordinates, and the output
// register, which offers the result word.
// Each stage holds its word until the next stage is free, so empty stages fill up even
// while the result register waits to be taken. The configuration port is always ready; its
// registers are to be written only while no point is in flight.
module perspective_point_projection_unit
    import ppp_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = 14
)(
    input  logic         clk,
    input  logic         rst_n,
    ppp_cfg_if.sink      cfg,
    ppp_point_if.sink    point,
    ppp_result_if.source result
);

    localparam int FRAC  = TRIG_FRAC_BITS;
    // Rotated x and z at scale 2^FRAC.
    localparam int MS_W  = M_W - FRAC;
    localparam int X2_W  = ((MS_W > TPROD_W) ? MS_W : TPROD_W) + 1;
    localparam int D_W   = X2_W - 1;
    // Integer part of the depth.
    localparam int ZI_W  = X2_W - FRAC;
    localparam int DX_W  = (ZI_W > DEPTH_W) ? ZI_W : DEPTH_W;
    // Projection numerators.
    localparam int CP_W  = X2_W + CREG_W + 1;
    localparam int YP_W  = Y1_W + CREG_W + 1;
    localparam int N_W   = ((CP_W > YP_W) ? CP_W : YP_W) + 1;
    localparam int CMP_W = (N_W > D_W + DIV_BITS) ? N_W : D_W + DIV_BITS;

    localparam logic signed [X2_W-1:0] NEAR_Q = X2_W'(NEAR_LIMIT) <<< FRAC;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [TRIG_W-1:0] cos_pitch_reg;
    logic signed [TRIG_W-1:0] sin_pitch_reg;
    logic signed [TRIG_W-1:0] cos_yaw_reg;
    logic signed [TRIG_W-1:0] sin_yaw_reg;
    logic [CREG_W-1:0]        cam_dist_reg;
    logic [CREG_W-1:0]        focal_reg;
    logic [CREG_W-1:0]        scr_cx_reg;
    logic [CREG_W-1:0]        scr_cy_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_pitch_reg <= RST_COS_PITCH;
            sin_pitch_reg <= RST_SIN_PITCH;
            cos_yaw_reg   <= RST_COS_YAW;
            sin_yaw_reg   <= RST_SIN_YAW;
            cam_dist_reg  <= RST_CAM_DIST;
            focal_reg     <= RST_FOCAL;
            scr_cx_reg    <= RST_SCR_CX;
            scr_cy_reg    <= RST_SCR_CY;
        end
        else if (cfg.valid)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_COS_PITCH: cos_pitch_reg <= $signed(cfg.data);
                REG_SIN_PITCH: sin_pitch_reg <= $signed(cfg.data);
                REG_COS_YAW:   cos_yaw_reg   <= $signed(cfg.data);
                REG_SIN_YAW:   sin_yaw_reg   <= $signed(cfg.data);
                REG_CAM_DIST:  cam_dist_reg  <= cfg.data[CREG_W-1:0];
                REG_FOCAL:     focal_reg     <= cfg.data[CREG_W-1:0];
                REG_SCR_CX:    scr_cx_reg    <= cfg.data[CREG_W-1:0];
                REG_SCR_CY:    scr_cy_reg    <= cfg.data[CREG_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage occupancy and flow control. A stage loads when it is empty or
    // when the stage after it loads too, so bubbles are squeezed out.
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] en;

    always_comb
    begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || result.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign point.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= point.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: capture the point and add the camera distance to z.
    // ------------------------------------------------------------------
    logic signed [PT_W-1:0] s0_px_reg;
    logic signed [PT_W-1:0] s0_py_reg;
    logic signed [Z0_W-1:0] s0_z0_reg;
    logic signed [Z0_W-1:0] s0_z0_next;

    assign s0_z0_next = Z0_W'(point.data.point_z) + $signed({2'b00, cam_dist_reg});

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_px_reg <= point.data.point_x;
            s0_py_reg <= point.data.point_y;
            s0_z0_reg <= s0_z0_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: all six products against the rotation registers.
    // ------------------------------------------------------------------
    logic signed [TPROD_W-1:0] s1_pcp_next, s1_psp_next, s1_pxc_next, s1_pxs_next;
    logic signed [ZPROD_W-1:0] s1_zsp_next, s1_zcp_next;
    logic signed [TPROD_W-1:0] s1_pcp_reg, s1_psp_reg, s1_pxc_reg, s1_pxs_reg;
    logic signed [ZPROD_W-1:0] s1_zsp_reg, s1_zcp_reg;

    assign s1_pcp_next = s0_py_reg * cos_pitch_reg;
    assign s1_psp_next = s0_py_reg * sin_pitch_reg;
    assign s1_zsp_next = s0_z0_reg * sin_pitch_reg;
    assign s1_zcp_next = s0_z0_reg * cos_pitch_reg;
    assign s1_pxc_next = s0_px_reg * cos_yaw_reg;
    assign s1_pxs_next = s0_px_reg * sin_yaw_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_pcp_reg <= s1_pcp_next;
            s1_psp_reg <= s1_psp_next;
            s1_zsp_reg <= s1_zsp_next;
            s1_zcp_reg <= s1_zcp_next;
            s1_pxc_reg <= s1_pxc_next;
            s1_pxs_reg <= s1_pxs_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: finish the pitch rotation. y1 and z1 are exact at 2^FRAC and
    // stay within 29 bits for any register contents.
    // ------------------------------------------------------------------
    logic signed [Y1_W-1:0]    s2_y1_next, s2_z1_next;
    logic signed [Y1_W-1:0]    s2_y1_reg, s2_z1_reg;
    logic signed [TPROD_W-1:0] s2_pxc_reg, s2_pxs_reg;

    assign s2_y1_next = Y1_W'(s1_pcp_reg - s1_zsp_reg);
    assign s2_z1_next = Y1_W'(s1_psp_reg + s1_zcp_reg);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_y1_reg  <= s2_y1_next;
            s2_z1_reg  <= s2_z1_next;
            s2_pxc_reg <= s1_pxc_reg;
            s2_pxs_reg <= s1_pxs_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: yaw products of z1.
    // ------------------------------------------------------------------
    logic signed [M_W-1:0]     s3_msy_next, s3_mcy_next;
    logic signed [M_W-1:0]     s3_msy_reg, s3_mcy_reg;
    logic signed [TPROD_W-1:0] s3_pxc_reg, s3_pxs_reg;
    logic signed [Y1_W-1:0]    s3_y1_reg;

    assign s3_msy_next = s2_z1_reg * sin_yaw_reg;
    assign s3_mcy_next = s2_z1_reg * cos_yaw_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_msy_reg <= s3_msy_next;
            s3_mcy_reg <= s3_mcy_next;
            s3_pxc_reg <= s2_pxc_reg;
            s3_pxs_reg <= s2_pxs_reg;
            s3_y1_reg  <= s2_y1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: finish the yaw rotation. The x terms carry no fraction bits,
    // so flooring the whole sum equals adding them to the floored z1 term.
    // ------------------------------------------------------------------
    logic signed [X2_W-1:0] s4_x2_next, s4_z2_next;
    logic signed [X2_W-1:0] s4_x2_reg, s4_z2_reg;
    logic signed [Y1_W-1:0] s4_y1_reg;

    assign s4_x2_next = X2_W'(s3_msy_reg >>> FRAC) + X2_W'(s3_pxc_reg);
    assign s4_z2_next = X2_W'(s3_mcy_reg >>> FRAC) - X2_W'(s3_pxs_reg);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_x2_reg <= s4_x2_next;
            s4_z2_reg <= s4_z2_next;
            s4_y1_reg <= s3_y1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: near-plane test, integer depth and the numerator products.
    // ------------------------------------------------------------------
    logic signed [CREG_W:0] cx_s, cy_s, foc_s;
    logic                   s5_vis_next;
    logic [ZI_W-1:0]        s5_zi;
    logic [DX_W-1:0]        s5_zx;
    logic [DEPTH_W-1:0]     s5_dep_next;
    logic signed [CP_W-1:0] s5_cxz_next, s5_x2f_next, s5_cyz_next;
    logic signed [YP_W-1:0] s5_y1f_next;

    logic                   s5_vis_reg;
    logic [DEPTH_W-1:0]     s5_dep_reg;
    logic [D_W-1:0]         s5_dvs_reg;
    logic signed [CP_W-1:0] s5_cxz_reg, s5_x2f_reg, s5_cyz_reg;
    logic signed [YP_W-1:0] s5_y1f_reg;

    assign cx_s  = $signed({1'b0, scr_cx_reg});
    assign cy_s  = $signed({1'b0, scr_cy_reg});
    assign foc_s = $signed({1'b0, focal_reg});

    assign s5_vis_next = s4_z2_reg > NEAR_Q;
    assign s5_zi       = s4_z2_reg[X2_W-1:FRAC];
    assign s5_zx       = DX_W'(s5_zi);
    assign s5_dep_next = (s5_zx > DX_W'(DEPTH_MAX)) ? DEPTH_MAX : s5_zx[DEPTH_W-1:0];

    assign s5_cxz_next = s4_z2_reg * cx_s;
    assign s5_x2f_next = s4_x2_reg * foc_s;
    assign s5_cyz_next = s4_z2_reg * cy_s;
    assign s5_y1f_next = s4_y1_reg * foc_s;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_vis_reg <= s5_vis_next;
            s5_dep_reg <= s5_dep_next;
            s5_dvs_reg <= s4_z2_reg[D_W-1:0];
            s5_cxz_reg <= s5_cxz_next;
            s5_x2f_reg <= s5_x2f_next;
            s5_cyz_reg <= s5_cyz_next;
            s5_y1f_reg <= s5_y1f_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: numerators. Lane 0 is screen x, lane 1 is screen y.
    // ------------------------------------------------------------------
    logic signed [N_W-1:0] s6_num_next [2];
    logic signed [N_W-1:0] s6_num_reg [2];
    logic                  s6_vis_reg;
    logic [DEPTH_W-1:0]    s6_dep_reg;
    logic [D_W-1:0]        s6_dvs_reg;

    assign s6_num_next[0] = N_W'(s5_cxz_reg) + N_W'(s5_x2f_reg);
    assign s6_num_next[1] = N_W'(s5_cyz_reg) - N_W'(s5_y1f_reg);

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_num_reg <= s6_num_next;
            s6_vis_reg <= s5_vis_reg;
            s6_dep_reg <= s5_dep_reg;
            s6_dvs_reg <= s5_dvs_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: sign and magnitude of each numerator; the divisor is positive
    // whenever the point is visible.
    // ------------------------------------------------------------------
    logic [N_W-1:0]     s7_mag_next [2];
    logic [1:0]         s7_neg_next;
    logic [N_W-1:0]     s7_mag_reg [2];
    logic [1:0]         s7_neg_reg;
    logic               s7_vis_reg;
    logic [DEPTH_W-1:0] s7_dep_reg;
    logic [D_W-1:0]     s7_dvs_reg;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            s7_neg_next[l] = s6_num_reg[l][N_W-1];
            s7_mag_next[l] = s6_num_reg[l][N_W-1] ? N_W'(-s6_num_reg[l])
                                                  : N_W'(s6_num_reg[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_mag_reg <= s7_mag_next;
            s7_neg_reg <= s7_neg_next;
            s7_vis_reg <= s6_vis_reg;
            s7_dep_reg <= s6_dep_reg;
            s7_dvs_reg <= s6_dvs_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider. The set-up stage flags quotients of 2^16 or more as overflow
    // and starts the partial remainder at the magnitude shifted down by 16,
    // which is then below the divisor. Each following stage brings in one
    // numerator bit and settles one quotient bit.
    // ------------------------------------------------------------------
    logic [CMP_W-1:0]     dv_mag_w [2];
    logic [1:0]           dv_ovf_next;

    logic [D_W-1:0]       rem_reg  [DIV_BITS][2];
    logic [DIV_BITS-1:0]  low_reg  [DIV_BITS][2];
    logic [DIV_BITS-1:0]  quo_reg  [DIV_BITS+1][2];
    logic [D_W-1:0]       dvs_reg  [DIV_BITS];
    div_ctl_t             dctl_reg [DIV_BITS+1];

    logic [D_W:0]         div_trial [1:DIV_BITS][2];
    logic [D_W:0]         div_diff  [1:DIV_BITS][2];
    logic                 div_ge    [1:DIV_BITS][2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            dv_mag_w[l]    = CMP_W'(s7_mag_reg[l]);
            dv_ovf_next[l] = dv_mag_w[l] >= CMP_W'({s7_dvs_reg, {DIV_BITS{1'b0}}});
        end
    end

    always_comb
    begin
        for (int j = 1; j <= DIV_BITS; j++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                div_trial[j][l] = {rem_reg[j-1][l], low_reg[j-1][l][DIV_BITS-1]};
                div_diff[j][l]  = div_trial[j][l] - {1'b0, dvs_reg[j-1]};
                div_ge[j][l]    = div_trial[j][l] >= {1'b0, dvs_reg[j-1]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[DIV_BASE])
        begin
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[0][l] <= dv_mag_w[l][D_W+DIV_BITS-1:DIV_BITS];
                low_reg[0][l] <= dv_mag_w[l][DIV_BITS-1:0];
                quo_reg[0][l] <= '0;
            end
            dvs_reg[0]  <= s7_dvs_reg;
            dctl_reg[0] <= '{visible: s7_vis_reg, depth: s7_dep_reg,
                             neg: s7_neg_reg, ovf: dv_ovf_next};
        end
        for (int j = 1; j <= DIV_BITS; j++)
        begin
            if (en[DIV_BASE+j])
            begin
                for (int l = 0; l < 2; l++)
                begin
                    quo_reg[j][l] <= {quo_reg[j-1][l][DIV_BITS-2:0], div_ge[j][l]};
                end
                dctl_reg[j] <= dctl_reg[j-1];
            end
        end
        for (int j = 1; j < DIV_BITS; j++)
        begin
            if (en[DIV_BASE+j])
            begin
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[j][l] <= div_ge[j][l] ? div_diff[j][l][D_W-1:0]
                                                  : div_trial[j][l][D_W-1:0];
                    low_reg[j][l] <= {low_reg[j-1][l][DIV_BITS-2:0], 1'b0};
                end
                dvs_reg[j] <= dvs_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: apply the sign, clamp to 16 bits and zero an invisible
    // point. A negative magnitude of exactly 32768 still fits.
    // ------------------------------------------------------------------
    logic signed [SCR_W-1:0] scr_next [2];
    logic [1:0]              sat_next;
    logic [DIV_BITS-1:0]     fin_q [2];
    div_ctl_t                fin_ctl;
    result_t                 res_next;
    result_t                 res_reg;

    assign fin_ctl = dctl_reg[DIV_BITS];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            fin_q[l] = quo_reg[DIV_BITS][l];
            priority if (fin_ctl.ovf[l])
            begin
                sat_next[l] = 1'b1;
                scr_next[l] = fin_ctl.neg[l] ? SCR_MIN : SCR_MAX;
            end
            else if (fin_ctl.neg[l])
            begin
                sat_next[l] = fin_q[l] > MAG_NEG_LIMIT;
                scr_next[l] = sat_next[l] ? SCR_MIN : $signed(-fin_q[l]);
            end
            else
            begin
                sat_next[l] = fin_q[l] > MAG_POS_LIMIT;
                scr_next[l] = sat_next[l] ? SCR_MAX : $signed(fin_q[l]);
            end
        end

        if (fin_ctl.visible)
        begin
            res_next = '{visible: 1'b1, screen_x: scr_next[0], screen_y: scr_next[1],
                         depth: fin_ctl.depth, saturated: |sat_next};
        end
        else
        begin
            res_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NUM_STAGES-1])
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid = vld_reg[NUM_STAGES-1];
    assign result.data  = res_reg;

endmodule
